[src/mpq_pkg.sv]
// Shared types and codes for the min priority queue.
`default_nettype none
package mpq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  localparam logic       CMD_ENQUEUE  = 1'b0;
  localparam logic       CMD_DEQUEUE  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage
`default_nettype wire

[src/min_priority_queue_linear_scan_top.sv]
// Min priority queue kept as an unsorted array in a single-port-read memory.
//
// An enqueue goes from idle straight to the finish state, which puts its result in the
// output register once that register is free; so does a dequeue on an empty queue. A
// dequeue on n stored entries makes one pass of n memory reads to find the first smallest
// entry. It then makes a second pass that moves each later entry one place toward the
// front. Both passes go through the one registered read port of the entry memory, one
// entry each cycle. The queue takes no new item while it works on an item. It does take
// one while an earlier result still waits in the output register.
`default_nettype none
module min_priority_queue_linear_scan_top #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      min_value,
  output logic [1:0]              status,
  output logic [6:0]              occupancy
);
  import mpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic signed [31:0] mem [DEPTH];

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic               cmd;
  logic [CW-1:0]      scan_idx;
  logic [CW-1:0]      rd_pos;
  logic               rd_vld;
  logic signed [31:0] rd_data;
  logic signed [31:0] best;
  logic [CW-1:0]      best_pos;

  logic               accept;
  logic               rd_en;
  logic               pass_done;
  logic               load_out;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;
  logic [CW-1:0]      rd_pos_m1;

  assign accept    = in_valid && !in_stall;
  assign rd_en     = (state == ST_SCAN || state == ST_SHIFT) && (scan_idx < count);
  assign pass_done = !rd_en && !rd_vld;
  assign rd_pos_m1 = rd_pos - CW'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_DEQUEUE && count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (pass_done) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (pass_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = value;
    res_value  = '0;
    res_status = STATUS_OK;
    count_next = count;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && command == CMD_ENQUEUE && count < DEPTH_C) begin
          wr_en = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (rd_vld) begin
          wr_en   = 1'b1;
          wr_addr = rd_pos_m1[AW-1:0];
          wr_data = rd_data;
        end
      end
      ST_FINISH: begin
        load_out = !out_valid || !out_stall;
        if (cmd == CMD_ENQUEUE) begin
          if (count < DEPTH_C) begin
            count_next = count + CW'(1);
          end else begin
            res_status = STATUS_FULL;
          end
        end else begin
          if (count == '0) begin
            res_status = STATUS_EMPTY;
          end else begin
            res_value  = best;
            count_next = count - CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[scan_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (load_out) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pos <= scan_idx;
    if (rd_en) begin
      scan_idx <= scan_idx + CW'(1);
    end
    if (accept) begin
      cmd      <= command;
      scan_idx <= '0;
    end
    if (state == ST_SCAN && rd_vld) begin
      if (rd_pos == '0 || rd_data < best) begin
        best     <= rd_data;
        best_pos <= rd_pos;
      end
    end
    if (state == ST_SCAN && pass_done) begin
      scan_idx <= best_pos + CW'(1);
    end
    if (load_out) begin
      min_value <= res_value;
      status    <= res_status;
      occupancy <= 7'(count_next);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !in_stall |-> state == ST_IDLE)
    else $error("input taken outside idle");

  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count above depth");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result shown without finishing an item");

  assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SCAN || state == ST_SHIFT))
    else $error("read data returned outside a pass");

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> $stable(count))
    else $error("entry count changed outside finish");

endmodule
`default_nettype wire
